FILE: design/necir_pkg.sv
package necir_pkg;

    // Fixed field widths of the request and result items.
    localparam int unsigned DURATION_IN_W = 24;
    localparam int unsigned NOW_W         = 32;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned REPEAT_W      = 32;
    localparam int unsigned TPU_W         = 8;
    localparam int unsigned WINDOW_W      = 16;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned CFG_INDEX_W   = 1;

    // Frame layout: leader mark, leader space, 32 bit pairs, trailing mark.
    localparam int unsigned FRAME_SPAN = 67;
    localparam int unsigned FRAME_BITS = 32;
    localparam int unsigned BIT_IDX_W  = 5;
    localparam int unsigned NOMINAL_W  = 14;
    localparam int unsigned PRODUCT_W  = NOMINAL_W + TPU_W;

    localparam logic [TPU_W-1:0]    TPU_RESET    = 8'd84;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd250;

    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_US  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_WINDOW = 1'd1;

    typedef struct packed {
        logic [DURATION_IN_W-1:0] duration;
        logic                     mark_ended;
        logic [NOW_W-1:0]         now_ms;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]   address;
        logic [BYTE_W-1:0]   command;
        logic [REPEAT_W-1:0] rpt_total;
    } t_out_item;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_hist_ctl;

    typedef enum logic [2:0] {
        NOM_560,
        NOM_1690,
        NOM_2250,
        NOM_4500,
        NOM_9000
    } t_nominal;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NEW,
        S_R2,
        S_R1,
        S_WIN,
        S_L1,
        S_L2,
        S_BM,
        S_BS,
        S_BS1,
        S_INV,
        S_EMIT
    } t_state;

    // Lower bound of a nominal length in microseconds (nominal minus a fifth).
    function automatic logic [NOMINAL_W-1:0] nominal_lo(input t_nominal nom);
        logic [NOMINAL_W-1:0] v;
        unique case (nom)
            NOM_560:  v = 14'd448;
            NOM_1690: v = 14'd1352;
            NOM_2250: v = 14'd1800;
            NOM_4500: v = 14'd3600;
            NOM_9000: v = 14'd7200;
            default:  v = '0;
        endcase
        return v;
    endfunction

    // Upper bound of a nominal length in microseconds (nominal plus a fifth).
    function automatic logic [NOMINAL_W-1:0] nominal_hi(input t_nominal nom);
        logic [NOMINAL_W-1:0] v;
        unique case (nom)
            NOM_560:  v = 14'd672;
            NOM_1690: v = 14'd2028;
            NOM_2250: v = 14'd2700;
            NOM_4500: v = 14'd5400;
            NOM_9000: v = 14'd10800;
            default:  v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/necir_hist.sv
module necir_hist #(
    parameter int unsigned HISTORY_DEPTH = 67,
    parameter int unsigned DURATION_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  necir_pkg::t_hist_ctl             i_ctl,
    input  logic [DURATION_BITS-1:0]         i_wr_data,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] i_rd_k,
    output logic [DURATION_BITS-1:0]         o_rd_data
);
    import necir_pkg::*;

    localparam int unsigned KW = $clog2(HISTORY_DEPTH);

    logic [DURATION_BITS-1:0] r_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_valid;
    logic [KW-1:0]            r_head;
    logic [DURATION_BITS-1:0] r_rdata;
    logic                     r_rvalid;
    logic [KW:0]              idx_sum;
    logic [KW-1:0]            rd_idx;

    // Entry k back from the newest sits at head - 1 - k, modulo the depth.
    always_comb begin
        idx_sum = (KW+1)'(r_head) + (KW+1)'(HISTORY_DEPTH - 1) - (KW+1)'(i_rd_k);
        if (idx_sum >= (KW+1)'(HISTORY_DEPTH)) begin
            rd_idx = KW'(idx_sum - (KW+1)'(HISTORY_DEPTH));
        end else begin
            rd_idx = KW'(idx_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[r_head] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_head   <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[r_head] <= 1'b1;
                if (r_head == KW'(HISTORY_DEPTH - 1)) begin
                    r_head <= '0;
                end else begin
                    r_head <= r_head + 1'b1;
                end
            end
            if (i_ctl.rd_en) begin
                r_rvalid <= r_valid[rd_idx];
            end
        end
    end

    // Entries not yet written since reset read as zero.
    assign o_rd_data = r_rvalid ? r_rdata : '0;

    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < KW'(HISTORY_DEPTH))
        else $error("history head out of range");

    a_head_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.wr_en && r_head != KW'(HISTORY_DEPTH - 1) |=> r_head == $past(r_head) + 1'b1)
        else $error("history head did not advance on a write");

    a_head_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.wr_en && r_head == KW'(HISTORY_DEPTH - 1) |=> r_head == '0)
        else $error("history head did not wrap");

endmodule

FILE: design/necir_range.sv
module necir_range #(
    parameter int unsigned DURATION_BITS = 24
) (
    input  logic [necir_pkg::TPU_W-1:0] i_tpu,
    input  necir_pkg::t_nominal         i_nominal,
    input  logic [DURATION_BITS-1:0]    i_duration,
    output logic                        o_match
);
    import necir_pkg::*;

    logic [PRODUCT_W-1:0] lo_ticks;
    logic [PRODUCT_W-1:0] hi_ticks;

    // Both bounds are small constants scaled by the tick rate.
    assign lo_ticks = PRODUCT_W'(nominal_lo(i_nominal)) * PRODUCT_W'(i_tpu);
    assign hi_ticks = PRODUCT_W'(nominal_hi(i_nominal)) * PRODUCT_W'(i_tpu);

    assign o_match = (32'(lo_ticks) <= 32'(i_duration)) && (32'(i_duration) <= 32'(hi_ticks));

endmodule

FILE: design/necir_seq.sv
module necir_seq #(
    parameter int unsigned HISTORY_DEPTH = 67,
    parameter int unsigned DURATION_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [necir_pkg::TPU_W-1:0]      i_tpu,
    input  logic [necir_pkg::WINDOW_W-1:0]   i_window,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  necir_pkg::t_in_item              i_in_item,
    output necir_pkg::t_hist_ctl             o_hist_ctl,
    output logic [DURATION_BITS-1:0]         o_hist_wr_data,
    output logic [$clog2(HISTORY_DEPTH)-1:0] o_hist_rd_k,
    input  logic [DURATION_BITS-1:0]         i_hist_rd_data,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output necir_pkg::t_out_item             o_res
);
    import necir_pkg::*;

    localparam int unsigned KW = $clog2(HISTORY_DEPTH);
    localparam logic [32:0] SAT_MAX = (33'd1 << DURATION_BITS) - 33'd1;

    t_state                   r_state, n_state;
    logic [DURATION_BITS-1:0] r_d, n_d;
    logic                     r_mark, n_mark;
    logic [NOW_W-1:0]         r_now, n_now;
    logic [BIT_IDX_W-1:0]     r_i, n_i;
    logic [FRAME_BITS-1:0]    r_bits, n_bits;
    t_out_item                r_res, n_res;
    logic [BYTE_W-1:0]        r_last_addr, n_last_addr;
    logic [BYTE_W-1:0]        r_last_cmd, n_last_cmd;
    logic [REPEAT_W-1:0]      r_reps, n_reps;
    logic [NOW_W-1:0]         r_last_ms, n_last_ms;

    t_nominal                 chk_nom;
    logic                     chk_newest;
    logic [DURATION_BITS-1:0] chk_d;
    logic                     chk_match;
    logic [31:0]              dur_wide;
    logic [31:0]              dur_sat;
    logic [NOW_W-1:0]         gap_ms;
    logic [KW-1:0]            k_space;
    logic [KW-1:0]            k_mark_next;
    logic [BIT_IDX_W-1:0]     i_next;

    necir_range #(
        .DURATION_BITS(DURATION_BITS)
    ) u_range (
        .i_tpu      (i_tpu),
        .i_nominal  (chk_nom),
        .i_duration (chk_d),
        .o_match    (chk_match)
    );

    assign chk_d = chk_newest ? r_d : i_hist_rd_data;

    assign dur_wide = 32'(i_in_item.duration);
    assign dur_sat  = (dur_wide > SAT_MAX[31:0]) ? SAT_MAX[31:0] : dur_wide;

    assign gap_ms = r_now - r_last_ms;

    // Bit i has its mark at FRAME_SPAN-3-2i and its space one entry newer.
    assign i_next      = r_i + 1'b1;
    assign k_space     = KW'(FRAME_SPAN - 4) - KW'({r_i, 1'b0});
    assign k_mark_next = KW'(FRAME_SPAN - 3) - KW'({i_next, 1'b0});

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = r_res;

    always_comb begin
        n_state     = r_state;
        n_d         = r_d;
        n_mark      = r_mark;
        n_now       = r_now;
        n_i         = r_i;
        n_bits      = r_bits;
        n_res       = r_res;
        n_last_addr = r_last_addr;
        n_last_cmd  = r_last_cmd;
        n_reps      = r_reps;
        n_last_ms   = r_last_ms;
        o_hist_ctl  = '0;
        o_hist_rd_k = '0;
        chk_nom     = NOM_560;
        chk_newest  = 1'b0;
        o_hist_wr_data = dur_sat[DURATION_BITS-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_hist_ctl.wr_en = 1'b1;
                    n_d     = dur_sat[DURATION_BITS-1:0];
                    n_mark  = i_in_item.mark_ended;
                    n_now   = i_in_item.now_ms;
                    n_state = S_NEW;
                end
            end
            S_NEW: begin
                chk_newest = 1'b1;
                if (r_mark && chk_match) begin
                    o_hist_ctl.rd_en = 1'b1;
                    o_hist_rd_k      = KW'(2);
                    n_state          = S_R2;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_R2: begin
                chk_nom          = NOM_9000;
                o_hist_ctl.rd_en = 1'b1;
                if (chk_match) begin
                    o_hist_rd_k = KW'(1);
                    n_state     = S_R1;
                end else begin
                    o_hist_rd_k = KW'(FRAME_SPAN - 1);
                    n_state     = S_L1;
                end
            end
            S_R1: begin
                chk_nom = NOM_2250;
                if (chk_match) begin
                    n_state = S_WIN;
                end else begin
                    o_hist_ctl.rd_en = 1'b1;
                    o_hist_rd_k      = KW'(FRAME_SPAN - 1);
                    n_state          = S_L1;
                end
            end
            S_WIN: begin
                // A repeat outside the window ends the request without a full-frame try.
                if (gap_ms <= NOW_W'(i_window)) begin
                    n_res.address   = r_last_addr;
                    n_res.command   = r_last_cmd;
                    n_res.rpt_total = r_reps + 1'b1;
                    n_state         = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_L1: begin
                chk_nom = NOM_9000;
                if (chk_match) begin
                    o_hist_ctl.rd_en = 1'b1;
                    o_hist_rd_k      = KW'(FRAME_SPAN - 2);
                    n_state          = S_L2;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_L2: begin
                chk_nom = NOM_4500;
                if (chk_match) begin
                    o_hist_ctl.rd_en = 1'b1;
                    o_hist_rd_k      = KW'(FRAME_SPAN - 3);
                    n_i              = '0;
                    n_state          = S_BM;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BM: begin
                if (chk_match) begin
                    o_hist_ctl.rd_en = 1'b1;
                    o_hist_rd_k      = k_space;
                    n_state          = S_BS;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BS, S_BS1: begin
                // A short space is a zero; otherwise the held entry is tried as a one.
                chk_nom = (r_state == S_BS) ? NOM_560 : NOM_1690;
                if (chk_match) begin
                    n_bits = {(r_state == S_BS1), r_bits[FRAME_BITS-1:1]};
                    if (r_i == BIT_IDX_W'(FRAME_BITS - 1)) begin
                        n_state = S_INV;
                    end else begin
                        n_i              = i_next;
                        o_hist_ctl.rd_en = 1'b1;
                        o_hist_rd_k      = k_mark_next;
                        n_state          = S_BM;
                    end
                end else if (r_state == S_BS) begin
                    n_state = S_BS1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_INV: begin
                if ((r_bits[7:0] == ~r_bits[15:8]) && (r_bits[23:16] == ~r_bits[31:24])) begin
                    n_res.address   = r_bits[7:0];
                    n_res.command   = r_bits[23:16];
                    n_res.rpt_total = '0;
                    n_state         = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_last_addr = r_res.address;
                    n_last_cmd  = r_res.command;
                    n_reps      = r_res.rpt_total;
                    n_last_ms   = r_now;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_addr <= '0;
            r_last_cmd  <= '0;
            r_reps      <= '0;
            r_last_ms   <= '0;
            r_i         <= '0;
        end else begin
            r_state     <= n_state;
            r_last_addr <= n_last_addr;
            r_last_cmd  <= n_last_cmd;
            r_reps      <= n_reps;
            r_last_ms   <= n_last_ms;
            r_i         <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d    <= n_d;
        r_mark <= n_mark;
        r_now  <= n_now;
        r_bits <= n_bits;
        r_res  <= n_res;
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_state == S_NEW)
        else $error("accepted request did not start a check");

    a_long_space_from_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BS1 |-> $past(r_state) == S_BS)
        else $error("second space check without a first");

    a_repeat_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WIN && n_state == S_EMIT |=> r_res.rpt_total == $past(r_reps) + 1'b1)
        else $error("repeat count not one above the stored count");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && i_res_ready |=> r_state == S_IDLE && r_reps == $past(r_res.rpt_total))
        else $error("result handoff did not update the frame state");

endmodule

FILE: design/nec_ir_frame_decoder_unit.sv
// NEC infrared frame decoder. Each request carries the length of one level
// from the IR receiver in timer ticks, a flag telling whether a mark ended,
// and a millisecond timestamp; the length is stored in a window of the last
// HISTORY_DEPTH lengths. A mark near 560 us that completes a repeat frame
// within the repeat window gives the last address and command with a bumped
// repeat count; one that completes a valid full frame gives its address and
// command with a repeat count of zero. A frame that passes the inversion check
// always has sixteen one bits. The checks run one after another on the single
// range comparator, which checks one stored length per cycle, and a space that
// is not a zero bit needs a second compare. The input stalls from acceptance
// until the block is back in idle. A result waits in the output register while
// the next request is worked on.
module nec_ir_frame_decoder_unit #(
    parameter int unsigned HISTORY_DEPTH = 67,
    parameter int unsigned DURATION_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [necir_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [necir_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  necir_pkg::t_in_item              i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output necir_pkg::t_out_item             o_out_item
);
    import necir_pkg::*;

    localparam int unsigned KW = $clog2(HISTORY_DEPTH);

    logic [TPU_W-1:0]         r_tpu;
    logic [WINDOW_W-1:0]      r_window;
    logic                     r_out_valid;
    t_out_item                r_out_item;

    t_hist_ctl                hist_ctl;
    logic [DURATION_BITS-1:0] hist_wr_data;
    logic [KW-1:0]            hist_rd_k;
    logic [DURATION_BITS-1:0] hist_rd_data;
    logic                     res_valid;
    logic                     res_ready;
    t_out_item                res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu    <= TPU_RESET;
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TICKS_PER_US:  r_tpu    <= i_cfg_data[TPU_W-1:0];
                CFG_REPEAT_WINDOW: r_window <= i_cfg_data[WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    necir_hist #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .DURATION_BITS(DURATION_BITS)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (hist_ctl),
        .i_wr_data (hist_wr_data),
        .i_rd_k    (hist_rd_k),
        .o_rd_data (hist_rd_data)
    );

    necir_seq #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .DURATION_BITS(DURATION_BITS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tpu          (r_tpu),
        .i_window       (r_window),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_item      (i_in_item),
        .o_hist_ctl     (hist_ctl),
        .o_hist_wr_data (hist_wr_data),
        .o_hist_rd_k    (hist_rd_k),
        .i_hist_rd_data (hist_rd_data),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res)
    );

    // The output register takes a new result when empty or being drained.
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import necir_pkg::*;

    localparam int unsigned HIST_DEPTH      = 67;
    localparam int unsigned MARK_US         = 560;
    localparam int unsigned ONE_SPACE_US    = 1690;
    localparam int unsigned REPEAT_SPACE_US = 2250;
    localparam int unsigned LEADER_SPACE_US = 4500;
    localparam int unsigned LEADER_MARK_US  = 9000;
    localparam int unsigned SETTLE_CYCLES   = 200;
    localparam int unsigned PHASE_ITEMS     = 450;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    t_in_item               i_in_item   = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_item              o_out_item;

    nec_ir_frame_decoder_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Decoder state as the testbench sees it.
    logic [DURATION_IN_W-1:0] hist_mem [HIST_DEPTH] = '{default: '0};
    int unsigned              hist_wr        = 0;
    logic [BYTE_W-1:0]        prior_addr     = '0;
    logic [BYTE_W-1:0]        prior_cmd      = '0;
    logic [REPEAT_W-1:0]      rpt_count      = '0;
    logic [NOW_W-1:0]         frame_stamp_ms = '0;
    logic [TPU_W-1:0]         cfg_tpu        = TPU_RESET;
    logic [WINDOW_W-1:0]      cfg_window     = WINDOW_RESET;

    t_in_item    pending_requests [$];
    t_out_item   expected_codes [$];
    int unsigned err_count = 0;
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned item_count = 0;
    logic [NOW_W-1:0] gen_clock_ms = '0;
    logic [NOW_W-1:0] gen_frame_ms = '0;

    task automatic log_mismatch(input string msg);
        if (err_count < 50) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        err_count++;
    endtask

    function automatic logic [31:0] band_lo(input int unsigned nom);
        return (nom - nom / 5) * cfg_tpu;
    endfunction

    function automatic logic [31:0] band_hi(input int unsigned nom);
        return (nom + nom / 5) * cfg_tpu;
    endfunction

    function automatic bit in_band(input logic [DURATION_IN_W-1:0] d, input int unsigned nom);
        return (band_lo(nom) <= 32'(d)) && (32'(d) <= band_hi(nom));
    endfunction

    // k = 0 is the newest stored length.
    function automatic logic [DURATION_IN_W-1:0] hist_at(input int unsigned k);
        return hist_mem[(hist_wr + HIST_DEPTH - 1 - k) % HIST_DEPTH];
    endfunction

    function automatic bit decode_edge(input t_in_item it, output t_out_item res);
        logic [31:0] bits;
        logic [31:0] gap;
        int unsigned i;
        res = '0;
        bits = '0;
        hist_mem[hist_wr] = it.duration;
        hist_wr = (hist_wr + 1) % HIST_DEPTH;
        if (!it.mark_ended || !in_band(it.duration, MARK_US)) return 1'b0;

        if (in_band(hist_at(2), LEADER_MARK_US) && in_band(hist_at(1), REPEAT_SPACE_US)) begin
            // A repeat pattern outside the window is dropped without looking for a frame.
            gap = it.now_ms - frame_stamp_ms;
            if (gap > 32'(cfg_window)) return 1'b0;
            rpt_count      = rpt_count + 1;
            frame_stamp_ms = it.now_ms;
            res.address   = prior_addr;
            res.command   = prior_cmd;
            res.rpt_total = rpt_count;
            return 1'b1;
        end

        if (!in_band(hist_at(HIST_DEPTH - 1), LEADER_MARK_US) ||
            !in_band(hist_at(HIST_DEPTH - 2), LEADER_SPACE_US)) return 1'b0;
        for (i = 0; i < 32; i++) begin
            if (!in_band(hist_at(HIST_DEPTH - 3 - 2 * i), MARK_US)) return 1'b0;
            if (!in_band(hist_at(HIST_DEPTH - 4 - 2 * i), MARK_US)) begin
                if (in_band(hist_at(HIST_DEPTH - 4 - 2 * i), ONE_SPACE_US)) begin
                    bits[i] = 1'b1;
                end else begin
                    return 1'b0;
                end
            end
        end
        if (bits[7:0] != ~bits[15:8] || bits[23:16] != ~bits[31:24]) return 1'b0;
        prior_addr     = bits[7:0];
        prior_cmd      = bits[23:16];
        rpt_count      = '0;
        frame_stamp_ms = it.now_ms;
        res.address   = bits[7:0];
        res.command   = bits[23:16];
        res.rpt_total = '0;
        return 1'b1;
    endfunction

    // Request driver.
    always @(posedge i_clk) begin
        t_out_item res;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (decode_edge(i_in_item, res)) expected_codes.push_back(res);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_requests.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
                    i_in_item  <= pending_requests.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_codes.size() == 0) begin
                log_mismatch($sformatf("unexpected result addr=%0h cmd=%0h rpt=%0d",
                    o_out_item.address, o_out_item.command, o_out_item.rpt_total));
            end else begin
                want = expected_codes.pop_front();
                if (o_out_item.address !== want.address)
                    log_mismatch($sformatf("address got %0h want %0h",
                        o_out_item.address, want.address));
                if (o_out_item.command !== want.command)
                    log_mismatch($sformatf("command got %0h want %0h",
                        o_out_item.command, want.command));
                if (o_out_item.rpt_total !== want.rpt_total)
                    log_mismatch($sformatf("repeat count got %0d want %0d",
                        o_out_item.rpt_total, want.rpt_total));
            end
        end
    end

    task automatic queue_raw(input logic [DURATION_IN_W-1:0] dur, input bit mark,
                             input logic [NOW_W-1:0] now);
        t_in_item it;
        it.duration   = dur;
        it.mark_ended = mark;
        it.now_ms     = now;
        pending_requests.push_back(it);
        item_count++;
    endtask

    task automatic queue_edge(input logic [DURATION_IN_W-1:0] dur, input bit mark);
        queue_raw(dur, mark, gen_clock_ms);
        gen_clock_ms = gen_clock_ms + $urandom_range(2, 0);
    endtask

    function automatic logic [DURATION_IN_W-1:0] pick_in_band(input int unsigned nom);
        int unsigned r;
        r = $urandom_range(19, 0);
        if (r == 0) return DURATION_IN_W'(band_lo(nom));
        if (r == 1) return DURATION_IN_W'(band_hi(nom));
        return DURATION_IN_W'($urandom_range(band_hi(nom), band_lo(nom)));
    endfunction

    function automatic logic [DURATION_IN_W-1:0] pick_off_band(input int unsigned nom);
        if (band_lo(nom) > 0 && $urandom_range(1, 0) == 1)
            return DURATION_IN_W'(band_lo(nom) - 1);
        return DURATION_IN_W'(band_hi(nom) + 1);
    endfunction

    // Full frame of 67 levels; cut_at below 67 stops it early.
    task automatic queue_frame(input bit corrupt, input int cut_at);
        logic [31:0] word;
        int          bad_pos;
        int          pos;
        int unsigned nom;
        bit          mark;
        logic [7:0]  addr;
        logic [7:0]  cmd;
        addr = 8'($urandom_range(255, 0));
        cmd  = 8'($urandom_range(255, 0));
        word = {~cmd, cmd, ~addr, addr};
        bad_pos = -1;
        if (corrupt) begin
            if ($urandom_range(1, 0) == 1) word[$urandom_range(31, 0)] ^= 1'b1;
            else bad_pos = $urandom_range(HIST_DEPTH - 1, 0);
        end
        for (pos = 0; pos < HIST_DEPTH && pos < cut_at; pos++) begin
            mark = (pos % 2 == 0);
            if (pos == 0) nom = LEADER_MARK_US;
            else if (pos == 1) nom = LEADER_SPACE_US;
            else if (mark) nom = MARK_US;
            else nom = word[(pos - 3) / 2] ? ONE_SPACE_US : MARK_US;
            queue_edge(pos == bad_pos ? pick_off_band(nom) : pick_in_band(nom), mark);
        end
        gen_frame_ms = gen_clock_ms;
    endtask

    task automatic queue_repeat();
        logic [NOW_W-1:0] gap;
        int               bad_pos;
        if ($urandom_range(99, 0) < 85) gap = $urandom_range(cfg_window, 0);
        else gap = cfg_window + 1 + $urandom_range(1000, 0);
        bad_pos = ($urandom_range(9, 0) == 0) ? $urandom_range(2, 0) : -1;
        gen_clock_ms = gen_frame_ms + gap;
        queue_raw(bad_pos == 0 ? pick_off_band(LEADER_MARK_US) : pick_in_band(LEADER_MARK_US),
            1'b1, gen_clock_ms);
        queue_raw(bad_pos == 1 ? pick_off_band(REPEAT_SPACE_US)
                               : pick_in_band(REPEAT_SPACE_US), 1'b0, gen_clock_ms);
        queue_raw(bad_pos == 2 ? pick_off_band(MARK_US) : pick_in_band(MARK_US),
            1'b1, gen_clock_ms);
        gen_frame_ms = gen_clock_ms;
    endtask

    task automatic queue_random_sequence();
        int unsigned r;
        int unsigned n;
        int unsigned noms [5];
        noms = '{MARK_US, ONE_SPACE_US, REPEAT_SPACE_US, LEADER_SPACE_US, LEADER_MARK_US};
        r = $urandom_range(99, 0);
        if (r < 3) gen_clock_ms = $urandom();
        else if (r < 5) gen_clock_ms = 32'hFFFF_FFFF - $urandom_range(50, 0);
        r = $urandom_range(99, 0);
        if (r < 45) begin
            queue_frame($urandom_range(4, 0) == 0, HIST_DEPTH);
        end else if (r < 70) begin
            queue_repeat();
        end else if (r < 85) begin
            n = $urandom_range(8, 1);
            repeat (n) queue_edge(DURATION_IN_W'($urandom()), 1'($urandom_range(1, 0)));
        end else if (r < 95) begin
            n = $urandom_range(8, 1);
            repeat (n) queue_edge(pick_in_band(noms[$urandom_range(4, 0)]),
                                  1'($urandom_range(1, 0)));
        end else begin
            queue_frame(1'b0, $urandom_range(HIST_DEPTH - 1, 1));
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TICKS_PER_US) cfg_tpu = val[TPU_W-1:0];
        else cfg_window = val;
    endtask

    // Waits until every request is accepted and every result is in, then lets the
    // block finish any check that cannot produce a result.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || expected_codes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [TPU_W-1:0] tpu, input logic [WINDOW_W-1:0] win,
                             input int unsigned idle, input int unsigned stall);
        int unsigned stop_at;
        write_reg(CFG_TICKS_PER_US, CFG_DATA_W'(tpu));
        write_reg(CFG_REPEAT_WINDOW, win);
        idle_pct  = idle;
        stall_pct = stall;
        stop_at = item_count + PHASE_ITEMS;
        while (item_count < stop_at) queue_random_sequence();
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under reset settings.
        queue_raw(24'hFF_FFFF, 1'b0, 32'd0);
        queue_raw(24'h00_0000, 1'b1, 32'd0);
        queue_raw(24'hFF_FFFF, 1'b1, 32'd0);
        // Repeat before any frame, then one just outside and one on the window edge.
        queue_raw(pick_in_band(LEADER_MARK_US), 1'b1, 32'd100);
        queue_raw(pick_in_band(REPEAT_SPACE_US), 1'b0, 32'd100);
        queue_raw(pick_in_band(MARK_US), 1'b1, 32'd100);
        queue_raw(pick_in_band(LEADER_MARK_US), 1'b1, 32'd351);
        queue_raw(pick_in_band(REPEAT_SPACE_US), 1'b0, 32'd351);
        queue_raw(pick_in_band(MARK_US), 1'b1, 32'd351);
        queue_raw(DURATION_IN_W'(band_hi(LEADER_MARK_US)), 1'b1, 32'd350);
        queue_raw(DURATION_IN_W'(band_lo(REPEAT_SPACE_US)), 1'b0, 32'd350);
        queue_raw(DURATION_IN_W'(band_hi(MARK_US)), 1'b1, 32'd350);
        queue_raw(DURATION_IN_W'(band_lo(MARK_US) - 1), 1'b1, 32'd360);
        queue_raw(DURATION_IN_W'(band_hi(MARK_US) + 1), 1'b1, 32'd360);
        wait_drained();

        // With zero ticks per microsecond only zero lengths match.
        write_reg(CFG_TICKS_PER_US, '0);
        queue_raw(24'd0, 1'b1, 32'd400);
        queue_raw(24'd0, 1'b0, 32'd400);
        queue_raw(24'd0, 1'b1, 32'd401);
        queue_raw(24'd1, 1'b1, 32'd402);
        queue_raw(24'd0, 1'b1, 32'd70000);
        wait_drained();

        gen_clock_ms = 32'd1000;
        gen_frame_ms = 32'd1000;
        run_phase(TPU_RESET, WINDOW_RESET, 0, 0);
        run_phase(8'd1, 16'd0, 71, 0);
        run_phase(8'd255, 16'hFFFF, 0, 71);
        run_phase(TPU_W'($urandom_range(255, 1)), WINDOW_W'($urandom_range(65535, 0)), 35, 35);

        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
